@@ design/rgbx_to_yuv420_quad_converter_unit_defines.svh @@
// Assertion helpers for the RGBx to YUV 4:2:0 quad converter.
// R2Y_ASSERT checks on every edge outside reset; R2Y_ASSERT_ALWAYS also during reset.
`ifndef RGBX_TO_YUV420_QUAD_CONVERTER_UNIT_DEFINES_SVH
`define RGBX_TO_YUV420_QUAD_CONVERTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define R2Y_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define R2Y_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define R2Y_ASSERT(lbl, clk, rst_n, prop, msg)
`define R2Y_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/r2y_pkg.sv @@
package r2y_pkg;

	localparam int FrameDimW = 13;
	localparam int CoordW    = 11;
	localparam int PixelW    = 32;
	localparam int CfgIdxW   = 2;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH     = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RED_IN_LOW_BYTE = 2'd2;

	localparam int FrameWidthReset  = 1920;
	localparam int FrameHeightReset = 1080;

	// BT.601 integer weights
	localparam logic [7:0] Y_R  = 8'd66;
	localparam logic [7:0] Y_G  = 8'd129;
	localparam logic [7:0] Y_B  = 8'd25;
	localparam logic [7:0] Y_OFS = 8'd16;
	localparam logic [7:0] U_R  = 8'd38;  // subtracted
	localparam logic [7:0] U_G  = 8'd74;  // subtracted
	localparam logic [7:0] U_B  = 8'd112;
	localparam logic [7:0] V_R  = 8'd112;
	localparam logic [7:0] V_G  = 8'd94;  // subtracted
	localparam logic [7:0] V_B  = 8'd18;  // subtracted

	typedef struct packed {
		logic [CoordW-1:0] block_column;
		logic [CoordW-1:0] block_row;
		logic [PixelW-1:0] pixel_top_left;
		logic [PixelW-1:0] pixel_top_right;
		logic [PixelW-1:0] pixel_bottom_left;
		logic [PixelW-1:0] pixel_bottom_right;
	} quad_t;

	typedef struct packed {
		logic       block_in_frame;
		logic [7:0] luma_top_left;
		logic [7:0] luma_top_right;
		logic [7:0] luma_bottom_left;
		logic [7:0] luma_bottom_right;
		logic [3:0] luma_valid_mask;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
	} result_t;

	typedef struct packed {
		logic [CfgIdxW-1:0]   index;
		logic [FrameDimW-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic rgb_t split_rgb(input logic [PixelW-1:0] px, input logic red_low);
		rgb_t c;
		c.g = px[15:8];
		c.r = red_low ? px[7:0] : px[23:16];
		c.b = red_low ? px[23:16] : px[7:0];
		return c;
	endfunction

endpackage

@@ design/r2y_stream_if.sv @@
interface r2y_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/rgbx_to_yuv420_quad_converter_unit.sv @@
// RGBx to YUV 4:2:0 quad converter. Each transfer on quad carries one 2x2 block of 32-bit
// RGBx pixels with its block coordinates; each transfer on result returns four Y values,
// a Y valid mask and one U/V pair (BT.601 integer weights, chroma from the average of the
// in-frame pixels). The block is a four-stage pipeline (channel split and frame checks,
// weighted sums, luma finish and chroma average, chroma products into the output
// register), so it takes one quad per clock while result is not stalled; back
// pressure on result stalls every full stage without losing or repeating anything. Frame size
// and byte order sit in registers written over cfg (always ready, one write per clock),
// which must only be written while no quad is in flight. Dimensions above MAX_FRAME_DIM
// are clamped on write.
`include "rgbx_to_yuv420_quad_converter_unit_defines.svh"

module rgbx_to_yuv420_quad_converter_unit
	import r2y_pkg::*;
#(
	parameter int MAX_FRAME_DIM = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	r2y_stream_if.sink               quad,
	r2y_stream_if.source             result,
	r2y_stream_if.sink               cfg
);

	// dimension width wide enough for the clamp value and the raw register
	localparam int ClogMax   = $clog2(MAX_FRAME_DIM + 1);
	localparam int DimW      = (ClogMax > FrameDimW) ? ClogMax : FrameDimW;
	localparam int CmpW      = DimW + 1;
	localparam int ResetW    = (FrameWidthReset > MAX_FRAME_DIM) ? MAX_FRAME_DIM
	                                                             : FrameWidthReset;
	localparam int ResetH    = (FrameHeightReset > MAX_FRAME_DIM) ? MAX_FRAME_DIM
	                                                              : FrameHeightReset;

	// ---------------- configuration ----------------
	// width/height are stored clamped, along with the half-size grid bound
	logic [DimW-1:0] width_q, height_q, half_w_q, half_h_q;
	logic            red_low_q;
	logic [DimW-1:0] cfg_dim;
	logic [DimW:0]   cfg_dim_p1;

	assign cfg.ready = 1'b1;

	always_comb begin
		cfg_dim    = DimW'(cfg.data.value);
		if (cfg_dim > DimW'(MAX_FRAME_DIM)) begin
			cfg_dim = DimW'(MAX_FRAME_DIM);
		end
		cfg_dim_p1 = {1'b0, cfg_dim} + (DimW+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DimW'(ResetW);
			height_q  <= DimW'(ResetH);
			half_w_q  <= DimW'((ResetW + 1) / 2);
			half_h_q  <= DimW'((ResetH + 1) / 2);
			red_low_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_FRAME_WIDTH: begin
					width_q  <= cfg_dim;
					half_w_q <= cfg_dim_p1[DimW:1];
				end
				CFG_FRAME_HEIGHT: begin
					height_q <= cfg_dim;
					half_h_q <= cfg_dim_p1[DimW:1];
				end
				CFG_RED_IN_LOW_BYTE: begin
					red_low_q <= cfg.data.value[0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- stall control ----------------
	// a stage loads when it is empty or its content moves on
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4      = !v_s4 || result.ready;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign quad.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= quad.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// ---------------- stage 1: frame checks, channel split ----------------
	logic       grid_s1, right_s1, bottom_s1;
	rgb_t       rgb_s1 [4];
	logic       grid_c, right_c, bottom_c;

	always_comb begin
		grid_c   = (CmpW'(quad.data.block_column) < CmpW'(half_w_q)) &&
		           (CmpW'(quad.data.block_row) < CmpW'(half_h_q));
		// 2*col+1 < width: right column exists
		right_c  = CmpW'({quad.data.block_column, 1'b1}) < CmpW'(width_q);
		bottom_c = CmpW'({quad.data.block_row, 1'b1}) < CmpW'(height_q);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			grid_s1   <= grid_c;
			right_s1  <= right_c;
			bottom_s1 <= bottom_c;
			rgb_s1[0] <= split_rgb(quad.data.pixel_top_left, red_low_q);
			rgb_s1[1] <= split_rgb(quad.data.pixel_top_right, red_low_q);
			rgb_s1[2] <= split_rgb(quad.data.pixel_bottom_left, red_low_q);
			rgb_s1[3] <= split_rgb(quad.data.pixel_bottom_right, red_low_q);
		end
	end

	// ---------------- stage 2: luma weighted sums, chroma channel sums ----------------
	logic [3:0]  mask_c;
	logic [1:0]  shift_c;
	logic [15:0] ywt_c [4];
	logic [9:0]  sum_r_c, sum_g_c, sum_b_c;

	logic [3:0]  mask_s2;
	logic [1:0]  shift_s2;
	logic [15:0] ywt_s2 [4];
	logic [9:0]  sum_r_s2, sum_g_s2, sum_b_s2;

	always_comb begin
		mask_c  = grid_s1 ? {right_s1 && bottom_s1, bottom_s1, right_s1, 1'b1} : 4'b0000;
		shift_c = 2'(right_s1) + 2'(bottom_s1);
		for (int i = 0; i < 4; i++) begin
			ywt_c[i] = 16'(Y_R) * 16'(rgb_s1[i].r) + 16'(Y_G) * 16'(rgb_s1[i].g) +
			           16'(Y_B) * 16'(rgb_s1[i].b);
		end
		sum_r_c = 10'(rgb_s1[0].r);
		sum_g_c = 10'(rgb_s1[0].g);
		sum_b_c = 10'(rgb_s1[0].b);
		for (int i = 1; i < 4; i++) begin
			if (mask_c[i]) begin
				sum_r_c = sum_r_c + 10'(rgb_s1[i].r);
				sum_g_c = sum_g_c + 10'(rgb_s1[i].g);
				sum_b_c = sum_b_c + 10'(rgb_s1[i].b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mask_s2  <= mask_c;
			shift_s2 <= shift_c;
			for (int i = 0; i < 4; i++) begin
				ywt_s2[i] <= ywt_c[i];
			end
			sum_r_s2 <= sum_r_c;
			sum_g_s2 <= sum_g_c;
			sum_b_s2 <= sum_b_c;
		end
	end

	// ---------------- stage 3: luma finish, chroma average ----------------
	logic [3:0] mask_s3;
	logic [7:0] luma_s3 [4];
	logic [7:0] avg_r_s3, avg_g_s3, avg_b_s3;
	logic [9:0] avg_r_c, avg_g_c, avg_b_c;

	always_comb begin
		// shift by log2 of the in-frame pixel count; result fits 8 bits
		avg_r_c = sum_r_s2 >> shift_s2;
		avg_g_c = sum_g_s2 >> shift_s2;
		avg_b_c = sum_b_s2 >> shift_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mask_s3 <= mask_s2;
			for (int i = 0; i < 4; i++) begin
				luma_s3[i] <= mask_s2[i] ? (ywt_s2[i][15:8] + Y_OFS) : 8'd0;
			end
			avg_r_s3 <= avg_r_c[7:0];
			avg_g_s3 <= avg_g_c[7:0];
			avg_b_s3 <= avg_b_c[7:0];
		end
	end

	// ---------------- stage 4: chroma products, output register ----------------
	logic [15:0] u_pos, u_neg, v_pos, v_neg;
	logic [16:0] u_c, v_c;
	result_t     res_c, res_s4;

	always_comb begin
		u_pos = 16'(U_B) * 16'(avg_b_s3);
		u_neg = 16'(U_R) * 16'(avg_r_s3) + 16'(U_G) * 16'(avg_g_s3);
		v_pos = 16'(V_R) * 16'(avg_r_s3);
		v_neg = 16'(V_G) * 16'(avg_g_s3) + 16'(V_B) * 16'(avg_b_s3);
		u_c   = {1'b0, u_pos} - {1'b0, u_neg};
		v_c   = {1'b0, v_pos} - {1'b0, v_neg};

		res_c.block_in_frame    = mask_s3[0];
		res_c.luma_top_left     = luma_s3[0];
		res_c.luma_top_right    = luma_s3[1];
		res_c.luma_bottom_left  = luma_s3[2];
		res_c.luma_bottom_right = luma_s3[3];
		res_c.luma_valid_mask   = mask_s3;
		// floor(x/256)+128 for a 16-bit signed x: high byte with its sign bit flipped
		res_c.chroma_u = mask_s3[0] ? {~u_c[15], u_c[14:8]} : 8'd0;
		res_c.chroma_v = mask_s3[0] ? {~v_c[15], v_c[14:8]} : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			res_s4 <= res_c;
		end
	end

	assign result.valid = v_s4;
	assign result.data  = res_s4;

	// ---------------- checks ----------------
	`R2Y_ASSERT(a_out_of_grid_zero, clk, arst_n, result.valid && !result.data.block_in_frame |-> result.data.luma_valid_mask == 4'b0000 && result.data.chroma_u == 8'd0 && result.data.chroma_v == 8'd0, "quad outside grid carries nonzero fields")
	`R2Y_ASSERT(a_corner_needs_edges, clk, arst_n, result.valid && result.data.luma_valid_mask[3] |-> result.data.luma_valid_mask[1] && result.data.luma_valid_mask[2], "bottom-right valid without right column and bottom row")
	`R2Y_ASSERT(a_stall_keeps_s4, clk, arst_n, v_s4 && !result.ready |=> v_s4 && $stable(res_s4), "output stage changed while stalled")
	`R2Y_ASSERT(a_dims_clamped, clk, arst_n, width_q <= DimW'(MAX_FRAME_DIM) && height_q <= DimW'(MAX_FRAME_DIM), "stored frame dimension above clamp")

endmodule

@@ sim/rgbx_to_yuv420_quad_converter_unit_tb.sv @@
module rgbx_to_yuv420_quad_converter_unit_tb;
	import r2y_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxFrameDim   = 4096;
	localparam int PipeLatency   = 4;     // quad in to result out, in pipeline stages
	localparam int IdleLimit     = 2000;  // cycles without any transfer before giving up
	localparam int LongHold      = 300;   // receiver hold-off used to back up the pipe
	localparam int PhaseQuads    = 55;
	localparam int NumPhases     = 10;

	// index 3 is not decoded; a write there must leave all registers alone
	localparam logic [CfgIdxW-1:0] CFG_UNUSED_INDEX = 2'd3;

	logic clk;
	logic arst_n;

	r2y_stream_if #(.payload_t(quad_t))   quad_bus ();
	r2y_stream_if #(.payload_t(result_t)) yuv_bus ();
	r2y_stream_if #(.payload_t(cfg_wr_t)) cfg_bus ();

	rgbx_to_yuv420_quad_converter_unit #(
		.MAX_FRAME_DIM(MaxFrameDim)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.quad  (quad_bus),
		.result(yuv_bus),
		.cfg   (cfg_bus)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Shadow copy of the frame registers, updated on each cfg transfer.
	logic [FrameDimW-1:0] shadow_width  = FrameDimW'(FrameWidthReset);
	logic [FrameDimW-1:0] shadow_height = FrameDimW'(FrameHeightReset);
	logic                 shadow_red_low = 1'b0;

	quad_t   quads_to_send[$];   // stimulus not yet put on the bus
	result_t expected_yuv[$];    // predicted results, oldest first

	int unsigned quads_queued    = 0;
	int unsigned quads_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches      = 0;
	int unsigned idle_cycles     = 0;

	// Back-pressure knobs, set by the sequencer between phases.
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	logic        long_hold      = 1'b0;
	logic        quad_moved     = 1'b0;

	// --- Predictor -------------------------------------------------------

	// Byte order: green always in the middle byte, red/blue swap on the flag.
	function automatic void unpack_rgb(input logic [31:0] px, output logic [7:0] r, g, b);
		g = px[15:8];
		if (shadow_red_low) begin
			r = px[7:0];
			b = px[23:16];
		end else begin
			r = px[23:16];
			b = px[7:0];
		end
	endfunction

	function automatic logic [7:0] luma_of_pixel(input logic [31:0] px);
		logic [7:0] r, g, b;
		int unsigned acc;
		unpack_rgb(px, r, g, b);
		acc = 66 * r + 129 * g + 25 * b;
		return 8'((acc >> 8) + 16);
	endfunction

	function automatic result_t convert_quad(input quad_t q);
		result_t     res;
		int unsigned w, h, col, row, shift;
		int unsigned sum_r, sum_g, sum_b;
		int          u, v;
		logic        right, bottom;
		logic [3:0]  present;
		logic [31:0] px[4];
		logic [7:0]  r, g, b;
		logic [7:0]  lum[4];
		res = '0;
		// oversized dimensions behave as the maximum; zero leaves an empty grid
		w = (shadow_width > MaxFrameDim) ? MaxFrameDim : shadow_width;
		h = (shadow_height > MaxFrameDim) ? MaxFrameDim : shadow_height;
		col = q.block_column;
		row = q.block_row;
		if (col >= ((w + 1) >> 1) || row >= ((h + 1) >> 1))
			return res;

		right   = (2 * col + 1) < w;
		bottom  = (2 * row + 1) < h;
		present = {right && bottom, bottom, right, 1'b1};
		px[0] = q.pixel_top_left;
		px[1] = q.pixel_top_right;
		px[2] = q.pixel_bottom_left;
		px[3] = q.pixel_bottom_right;

		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		for (int i = 0; i < 4; i++) begin
			lum[i] = '0;
			if (present[i]) begin
				lum[i] = luma_of_pixel(px[i]);
				unpack_rgb(px[i], r, g, b);
				sum_r += r;
				sum_g += g;
				sum_b += b;
			end
		end
		// one, two or four pixels -> shift by 0, 1 or 2
		shift = int'(right) + int'(bottom);
		sum_r >>= shift;
		sum_g >>= shift;
		sum_b >>= shift;

		// floor(x / 256) + 128 == bits 15:8 of x + 32768 for |x| < 32768
		u = -38 * int'(sum_r) - 74 * int'(sum_g) + 112 * int'(sum_b) + 32768;
		v = 112 * int'(sum_r) - 94 * int'(sum_g) - 18 * int'(sum_b) + 32768;

		res.block_in_frame    = 1'b1;
		res.luma_top_left     = lum[0];
		res.luma_top_right    = lum[1];
		res.luma_bottom_left  = lum[2];
		res.luma_bottom_right = lum[3];
		res.luma_valid_mask   = present;
		res.chroma_u          = u[15:8];
		res.chroma_v          = v[15:8];
		return res;
	endfunction

	// --- Stimulus helpers ------------------------------------------------

	function automatic quad_t make_quad(input int unsigned col, row,
			input logic [31:0] tl, tr, bl, br);
		quad_t q;
		q.block_column       = CoordW'(col);
		q.block_row          = CoordW'(row);
		q.pixel_top_left     = tl;
		q.pixel_top_right    = tr;
		q.pixel_bottom_left  = bl;
		q.pixel_bottom_right = br;
		return q;
	endfunction

	function automatic logic [31:0] random_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return $urandom() | 32'h00ff00ff;
			default: return $urandom();
		endcase
	endfunction

	// Coordinate biased toward the grid edge: last in-grid index, first outside,
	// anywhere inside, or anywhere in the 11-bit range.
	function automatic int unsigned random_coord(input int unsigned dim);
		int unsigned d, half;
		d    = (dim > MaxFrameDim) ? MaxFrameDim : dim;
		half = (d + 1) >> 1;
		case ($urandom_range(9))
			0, 1, 2: return $urandom_range(2047);
			3, 4, 5: return (half == 0) ? 0 : $urandom_range(half - 1);
			6, 7:    return (half == 0) ? 0 : half - 1;
			default: return (half > 2047) ? 2047 : half;
		endcase
	endfunction

	task automatic queue_quad(input quad_t q);
		quads_to_send.insert(quads_to_send.size(), q);
		quads_queued++;
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [FrameDimW-1:0] val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= '{index: idx, value: val};
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic set_frame(input int unsigned w, h, input logic red_low);
		write_reg(CFG_FRAME_WIDTH, FrameDimW'(w));
		write_reg(CFG_FRAME_HEIGHT, FrameDimW'(h));
		write_reg(CFG_RED_IN_LOW_BYTE, FrameDimW'(red_low));
	endtask

	// Every quad yields exactly one result, so drained means all results seen.
	// The extra cycles let anything stray surface before registers change.
	task automatic wait_drained();
		wait (quads_sent == quads_queued && results_checked >= quads_queued);
		repeat (PipeLatency + 2) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// --- Quad driver: changes on the falling edge ------------------------
	// A new item goes out once the previous one transferred (or the bus was
	// idle); random gaps per src_idle_pct.
	always @(negedge clk) begin
		if (!arst_n) begin
			quad_bus.valid <= 1'b0;
		end else if (!quad_bus.valid || quad_moved) begin
			if (quads_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				quad_bus.valid <= 1'b1;
				quad_bus.data  <= quads_to_send.pop_front();
			end else begin
				quad_bus.valid <= 1'b0;
			end
		end
	end

	// Result receiver ready: random stalls plus the long hold-off.
	always @(negedge clk) begin
		if (!arst_n)
			yuv_bus.ready <= 1'b0;
		else
			yuv_bus.ready <= !long_hold && ($urandom_range(99) >= sink_stall_pct);
	end

	// --- Monitor: samples on the rising edge -----------------------------
	always @(posedge clk) begin
		result_t want;
		quad_moved <= arst_n && quad_bus.valid && quad_bus.ready;
		if (arst_n) begin
			// predict with the registers as they stand; they only change while idle
			if (quad_bus.valid && quad_bus.ready) begin
				expected_yuv.insert(expected_yuv.size(), convert_quad(quad_bus.data));
				quads_sent++;
			end

			if (yuv_bus.valid && yuv_bus.ready) begin
				results_checked++;
				if (expected_yuv.size() == 0) begin
					$error("result transfer with no quad outstanding");
					mismatches++;
				end else begin
					want = expected_yuv.pop_front();
					check_field("block_in_frame", 8'(want.block_in_frame),
						8'(yuv_bus.data.block_in_frame));
					check_field("luma_top_left", want.luma_top_left,
						yuv_bus.data.luma_top_left);
					check_field("luma_top_right", want.luma_top_right,
						yuv_bus.data.luma_top_right);
					check_field("luma_bottom_left", want.luma_bottom_left,
						yuv_bus.data.luma_bottom_left);
					check_field("luma_bottom_right", want.luma_bottom_right,
						yuv_bus.data.luma_bottom_right);
					check_field("luma_valid_mask", 8'(want.luma_valid_mask),
						8'(yuv_bus.data.luma_valid_mask));
					check_field("chroma_u", want.chroma_u, yuv_bus.data.chroma_u);
					check_field("chroma_v", want.chroma_v, yuv_bus.data.chroma_v);
				end
			end

			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.data.index)
					CFG_FRAME_WIDTH:     shadow_width   = cfg_bus.data.value;
					CFG_FRAME_HEIGHT:    shadow_height  = cfg_bus.data.value;
					CFG_RED_IN_LOW_BYTE: shadow_red_low = cfg_bus.data.value[0];
					default: ;
				endcase
			end

			// watchdog: any transfer on any channel counts as progress
			if ((quad_bus.valid && quad_bus.ready) || (yuv_bus.valid && yuv_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles = idle_cycles + 1;
				if (idle_cycles >= IdleLimit) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// --- Sequencer -------------------------------------------------------
	initial begin
		int unsigned w, h;
		logic        red_low;

		quad_bus.valid = 1'b0;
		quad_bus.data  = '0;
		yuv_bus.ready  = 1'b0;
		cfg_bus.valid  = 1'b0;
		cfg_bus.data   = '0;
		arst_n         = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset registers (1920x1080, red in the third byte):
		// black, white, pure primaries, last quad of the grid, first quads
		// outside in each direction, coordinate extremes.
		queue_quad(make_quad(0, 0, '0, '0, '0, '0));
		queue_quad(make_quad(0, 0, '1, '1, '1, '1));
		queue_quad(make_quad(959, 539, 32'h00ff0000, 32'h00ff0000, 32'h00ff0000, 32'h00ff0000));
		queue_quad(make_quad(1, 1, 32'h0000ff00, 32'h0000ff00, 32'h0000ff00, 32'h0000ff00));
		queue_quad(make_quad(2, 3, 32'h000000ff, 32'h000000ff, 32'h000000ff, 32'h000000ff));
		queue_quad(make_quad(959, 0, '1, '0, '0, 32'hff000000));
		queue_quad(make_quad(960, 0, '1, '1, '1, '1));
		queue_quad(make_quad(0, 540, '1, '1, '1, '1));
		queue_quad(make_quad(2047, 2047, '1, '1, '1, '1));
		queue_quad(make_quad(1023, 200, 32'h12345678, '1, '1, '1));
		wait_drained();

		// Odd frame with red in the low byte: right column and/or bottom row
		// fall outside, giving one-, two- and four-pixel averages.
		set_frame(1919, 1079, 1'b1);
		queue_quad(make_quad(959, 539, 32'h000000ff, '1, '1, '1));
		queue_quad(make_quad(959, 0, 32'h12345678, 32'h9abcdef0, 32'h0f1e2d3c, '1));
		queue_quad(make_quad(0, 539, 32'hfedcba98, 32'h00ff00ff, '1, '1));
		queue_quad(make_quad(958, 538, 32'h000000ff, 32'h0000ff00, 32'h00ff0000, 32'hff000000));
		queue_quad(make_quad(959, 539, '1, '0, '0, '0));
		queue_quad(make_quad(960, 0, '1, '1, '1, '1));
		wait_drained();

		// Random phases: each one its own register setting and idle pattern.
		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				0: begin w = 4096; h = 4096; red_low = 1'b1; end  // largest grid
				1: begin w = 1;    h = 1;    red_low = 1'b0; end  // single pixel
				2: begin w = 0;    h = 5;    red_low = 1'b1; end  // empty grid
				3: begin w = 8191; h = 4097; red_low = 1'b0; end  // clamped
				4: begin w = 3;    h = 2;    red_low = 1'b1; end
				5: begin w = 5;    h = 0;    red_low = 1'b0; end
				default: begin
					w = $urandom_range(4096, 1);
					h = $urandom_range(4096, 1);
					red_low = 1'($urandom());
				end
			endcase
			set_frame(w, h, red_low);
			if (p == 3)
				write_reg(CFG_UNUSED_INDEX, FrameDimW'($urandom()));

			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
				default: begin src_idle_pct = 24; sink_stall_pct = 24; end
			endcase

			for (int i = 0; i < PhaseQuads; i++)
				queue_quad(make_quad(random_coord(shadow_width), random_coord(shadow_height),
					random_pixel(), random_pixel(), random_pixel(), random_pixel()));

			// First phase: hold the receiver off while the sender keeps
			// offering, so the pipe fills and quad ready drops.
			if (p == 0) begin
				@(posedge clk);
				long_hold = 1'b1;
				repeat (LongHold) @(posedge clk);
				long_hold = 1'b0;
			end
			wait_drained();
		end

		src_idle_pct   = 0;
		sink_stall_pct = 0;
		wait_drained();
		repeat (PipeLatency * 2) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/r2y_pkg.sv
design/r2y_stream_if.sv
design/rgbx_to_yuv420_quad_converter_unit.sv
sim/rgbx_to_yuv420_quad_converter_unit_tb.sv
